/* hw/rtl/ltbi_pkg.sv */
package ltbi_pkg;

  localparam int TEMP_POINTS = 32;
  localparam int DENS_POINTS = 32;
  localparam int STAGES      = 16;
  localparam int TABLE_SIZE  = STAGES * TEMP_POINTS * DENS_POINTS;

  localparam int TPW    = (TEMP_POINTS > 2) ? $clog2(TEMP_POINTS) : 1;
  localparam int DPW    = (DENS_POINTS > 2) ? $clog2(DENS_POINTS) : 1;
  localparam int CW     = $clog2(TABLE_SIZE);
  localparam int MAXP   = (TEMP_POINTS > DENS_POINTS) ? TEMP_POINTS : DENS_POINTS;
  localparam int SCAN_W = $clog2(MAXP + 1);

  localparam int               ONE_Q16   = 65536;
  localparam logic signed [23:0] FLOOR_LOG = -24'sd327680;
  localparam logic [5:0]       POINTS_RESET = 6'd32;

  typedef enum logic [1:0] {
    MODE_LD_TEMP  = 2'd0,
    MODE_LD_DENS  = 2'd1,
    MODE_LD_COEFF = 2'd2,
    MODE_EVAL     = 2'd3
  } mode_e;

  typedef enum logic [0:0] {
    REG_TEMP_POINTS = 1'b0,
    REG_DENS_POINTS = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_BELOW = 2'd1,
    CLAMP_ABOVE = 2'd2
  } clamp_e;

  typedef enum logic [1:0] {
    GRD_NONE = 2'd0,
    GRD_LO   = 2'd1,
    GRD_HI   = 2'd2
  } grd_e;

  typedef enum logic [2:0] {
    MAC_C00 = 3'd0,
    MAC_C01 = 3'd1,
    MAC_C10 = 3'd2,
    MAC_C11 = 3'd3,
    MAC_ALO = 3'd4,
    MAC_AHI = 3'd5,
    MAC_BLO = 3'd6,
    MAC_BHI = 3'd7
  } mac_op_e;

  typedef struct packed {
    logic    accept;
    logic    eval_start;
    logic    scan;
    logic    resolve;
    grd_e    grd;
    logic    div_start;
    logic    crd_en;
    logic [1:0] corner;
    logic    mac_en;
    mac_op_e mac_op;
    logic    out_load;
  } ltbi_cmd_t;

  typedef struct packed {
    logic in_eval;
    logic scan_done;
    logic div_busy;
  } ltbi_status_t;

  function automatic logic [SCAN_W-1:0] points_in_use(logic [5:0] r, int lim);
    int n;
    n = int'(r);
    if (n < 2) n = 2;
    if (n > lim) n = lim;
    return SCAN_W'(n);
  endfunction

  function automatic logic [CW-1:0] coeff_addr(logic [3:0] st, logic [7:0] ti,
                                               logic [7:0] di);
    int a;
    a = (int'(st) * TEMP_POINTS + int'(ti)) * DENS_POINTS + int'(di);
    return CW'(a);
  endfunction

endpackage

/* hw/rtl/ltbi_if.sv */
interface ltbi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [3:0]         stage;
  logic [4:0]         temp_index;
  logic [4:0]         dens_index;
  logic signed [23:0] load_value;
  logic signed [23:0] log_temp;
  logic signed [23:0] log_dens;

  modport source (output valid, mode, stage, temp_index, dens_index, load_value,
                  log_temp, log_dens, input ready);
  modport sink (input valid, mode, stage, temp_index, dens_index, load_value,
                log_temp, log_dens, output ready);
endinterface

interface ltbi_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] log_rate;
  logic [1:0]         temp_clamp;
  logic [1:0]         dens_clamp;

  modport source (output valid, log_rate, temp_clamp, dens_clamp, input ready);
  modport sink (input valid, log_rate, temp_clamp, dens_clamp, output ready);
endinterface

interface ltbi_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [5:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/log_table_bilinear_interp.sv */
// Load items give no result.
// For an evaluate item, the linear grid scan reads one point per cycle over the larger number
// of grid points in use, and the two weight dividers produce one quotient bit per cycle; a
// divider runs only when its weight needs a division.
// One item is in work at a time; the result register frees the input while it waits.
// Reset sets both point counts to 32 and idles the controller; the stores are not cleared.
module log_table_bilinear_interp (
  input  logic       clk_i,
  input  logic       rst_ni,
  ltbi_in_if.sink    in_i,
  ltbi_out_if.source out_o,
  ltbi_cfg_if.sink   cfg_i
);

  ltbi_pkg::ltbi_cmd_t    cmd;
  ltbi_pkg::ltbi_status_t status;
  logic                   in_ready;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  ltbi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ltbi_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .mode_i       (in_i.mode),
    .stage_i      (in_i.stage),
    .temp_index_i (in_i.temp_index),
    .dens_index_i (in_i.dens_index),
    .load_value_i (in_i.load_value),
    .log_temp_i   (in_i.log_temp),
    .log_dens_i   (in_i.log_dens),
    .log_rate_o   (out_o.log_rate),
    .temp_clamp_o (out_o.temp_clamp),
    .dens_clamp_o (out_o.dens_clamp)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.temp_clamp != 2'd3 && out_o.dens_clamp != 2'd3))
    else $error("Result carries an invalid clamp code.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan |-> !in_ready)
    else $error("Input open during a grid scan.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready && in_i.mode == ltbi_pkg::MODE_EVAL) |=> !in_ready)
    else $error("Input still open after an evaluate transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !status.div_busy)
    else $error("Result loaded while a divider is busy.");

endmodule

/* hw/rtl/ltbi_div.sv */
module ltbi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [24:0] num_i,
  input  logic signed [24:0] den_i,
  output logic               busy_o,
  output logic [16:0]        quot_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [24:0] rem_q;
  logic [24:0] den_q;
  logic [16:0] quot_q;
  logic [24:0] rem_sh;

  assign rem_sh = {rem_q[23:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      if (den_i > 0 && num_i > 0 && num_i < den_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else begin
        busy_q <= 1'b0;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      if (den_i <= 0 || num_i <= 0) begin
        quot_q <= '0;
      end else if (num_i >= den_i) begin
        quot_q <= 17'(ltbi_pkg::ONE_Q16);
      end else begin
        quot_q <= '0;
      end
    end else if (busy_q) begin
      if (rem_sh >= den_q) begin
        rem_q  <= rem_sh - den_q;
        quot_q <= {quot_q[15:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[15:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

/* hw/rtl/ltbi_ctrl.sv */
module ltbi_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  ltbi_pkg::ltbi_status_t status_i,
  output ltbi_pkg::ltbi_cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_SCAN    = 12'b000000000010,
    S_RESOLVE = 12'b000000000100,
    S_RDLO    = 12'b000000001000,
    S_RDHI    = 12'b000000010000,
    S_GRDW    = 12'b000000100000,
    S_DIVS    = 12'b000001000000,
    S_DIVW    = 12'b000010000000,
    S_CORNER  = 12'b000100000000,
    S_MAC     = 12'b001000000000,
    S_FINISH  = 12'b010000000000,
    S_SPARE   = 12'b100000000000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.in_eval) begin
            cmd_o.eval_start = 1'b1;
            state_d          = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        state_d       = S_RDLO;
      end
      S_RDLO: begin
        cmd_o.grd = ltbi_pkg::GRD_LO;
        state_d   = S_RDHI;
      end
      S_RDHI: begin
        cmd_o.grd = ltbi_pkg::GRD_HI;
        state_d   = S_GRDW;
      end
      S_GRDW: begin
        state_d = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVW;
      end
      S_DIVW: begin
        if (!status_i.div_busy) begin
          cnt_d   = '0;
          state_d = S_CORNER;
        end
      end
      S_CORNER: begin
        cmd_o.crd_en = 1'b1;
        cmd_o.corner = cnt_q[1:0];
        cnt_d        = cnt_q + 4'd1;
        if (cnt_q == 4'd3) begin
          cnt_d   = '0;
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        cmd_o.mac_en = !cnt_q[3];
        cmd_o.mac_op = ltbi_pkg::mac_op_e'(cnt_q[2:0]);
        cnt_d        = cnt_q + 4'd1;
        if (cnt_q[3]) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/ltbi_dp.sv */
module ltbi_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ltbi_pkg::ltbi_cmd_t    cmd_i,
  output ltbi_pkg::ltbi_status_t status_o,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_index_i,
  input  logic [5:0]             cfg_data_i,
  input  logic [1:0]             mode_i,
  input  logic [3:0]             stage_i,
  input  logic [4:0]             temp_index_i,
  input  logic [4:0]             dens_index_i,
  input  logic signed [23:0]     load_value_i,
  input  logic signed [23:0]     log_temp_i,
  input  logic signed [23:0]     log_dens_i,
  output logic signed [23:0]     log_rate_o,
  output logic [1:0]             temp_clamp_o,
  output logic [1:0]             dens_clamp_o
);

  localparam int TW = ltbi_pkg::TPW;
  localparam int DW = ltbi_pkg::DPW;
  localparam int SW = ltbi_pkg::SCAN_W;
  localparam int AW = ltbi_pkg::CW;

  logic [5:0]    tpu_q, dpu_q;
  logic [SW-1:0] nt, nd, nmax;

  logic signed [23:0] tg_mem [ltbi_pkg::TEMP_POINTS];
  logic signed [23:0] dg_mem [ltbi_pkg::DENS_POINTS];
  logic signed [23:0] cf_mem [ltbi_pkg::TABLE_SIZE];
  logic signed [23:0] tg_rd_q, dg_rd_q, cf_rd_q;
  logic [TW-1:0]      t_raddr;
  logic [DW-1:0]      d_raddr;
  logic [AW-1:0]      c_raddr, c_waddr;

  logic signed [23:0] xt_q, xd_q;
  logic [3:0]         stage_q;
  logic [SW-1:0]      sc_q, tag_q, idx_t_q, idx_d_q;
  logic               vld_q, found_t_q, found_d_q;
  ltbi_pkg::clamp_e   flag_t_q, flag_d_q;
  logic [TW-1:0]      lo_t_q;
  logic [DW-1:0]      lo_d_q;
  ltbi_pkg::grd_e     grd_q;
  logic signed [23:0] glo_t_q, ghi_t_q, glo_d_q, ghi_d_q;
  logic signed [23:0] xe_t, xe_d;
  logic signed [24:0] num_t, den_t, num_d, den_d;
  logic               busy_t, busy_d;
  logic [16:0]        wt, wd, om_wt, om_wd;

  logic signed [23:0] c_q [4];
  logic [1:0]         csel_q;
  logic               cv_q;

  logic signed [24:0] opa;
  logic signed [17:0] opb;
  logic signed [42:0] p_q;
  logic signed [57:0] p_ext;
  ltbi_pkg::mac_op_e  mop_q;
  logic               mv_q;
  logic signed [40:0] acc_a_q, acc_b_q;
  logic signed [57:0] acc_q, rsum;
  logic signed [25:0] rnd;
  logic signed [23:0] sat;

  logic               ld_temp, ld_dens, ld_coeff;

  assign nt   = ltbi_pkg::points_in_use(tpu_q, ltbi_pkg::TEMP_POINTS);
  assign nd   = ltbi_pkg::points_in_use(dpu_q, ltbi_pkg::DENS_POINTS);
  assign nmax = (nt > nd) ? nt : nd;

  assign status_o.in_eval   = (mode_i == ltbi_pkg::MODE_EVAL);
  assign status_o.scan_done = vld_q && (tag_q == nmax - SW'(1));
  assign status_o.div_busy  = busy_t || busy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q <= ltbi_pkg::POINTS_RESET;
      dpu_q <= ltbi_pkg::POINTS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ltbi_pkg::REG_TEMP_POINTS: tpu_q <= cfg_data_i;
        ltbi_pkg::REG_DENS_POINTS: dpu_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Loads that address beyond a store are dropped.
  assign ld_temp  = cmd_i.accept && mode_i == ltbi_pkg::MODE_LD_TEMP &&
                    int'(temp_index_i) < ltbi_pkg::TEMP_POINTS;
  assign ld_dens  = cmd_i.accept && mode_i == ltbi_pkg::MODE_LD_DENS &&
                    int'(dens_index_i) < ltbi_pkg::DENS_POINTS;
  assign ld_coeff = cmd_i.accept && mode_i == ltbi_pkg::MODE_LD_COEFF &&
                    int'(stage_i) < ltbi_pkg::STAGES &&
                    int'(temp_index_i) < ltbi_pkg::TEMP_POINTS &&
                    int'(dens_index_i) < ltbi_pkg::DENS_POINTS;
  assign c_waddr  = ltbi_pkg::coeff_addr(stage_i, 8'(temp_index_i), 8'(dens_index_i));

  always_comb begin
    case (cmd_i.grd)
      ltbi_pkg::GRD_LO: begin
        t_raddr = lo_t_q;
        d_raddr = lo_d_q;
      end
      ltbi_pkg::GRD_HI: begin
        t_raddr = lo_t_q + TW'(1);
        d_raddr = lo_d_q + DW'(1);
      end
      default: begin
        t_raddr = TW'(sc_q);
        d_raddr = DW'(sc_q);
      end
    endcase
  end

  assign c_raddr = ltbi_pkg::coeff_addr(stage_q, 8'(lo_t_q) + 8'(cmd_i.corner[1]),
                                        8'(lo_d_q) + 8'(cmd_i.corner[0]));

  always_ff @(posedge clk_i) begin
    if (ld_temp) begin
      tg_mem[TW'(temp_index_i)] <= load_value_i;
    end
    tg_rd_q <= tg_mem[t_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ld_dens) begin
      dg_mem[DW'(dens_index_i)] <= load_value_i;
    end
    dg_rd_q <= dg_mem[d_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ld_coeff) begin
      cf_mem[c_waddr] <= load_value_i;
    end
    cf_rd_q <= cf_mem[c_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_start) begin
      xt_q    <= (log_temp_i < ltbi_pkg::FLOOR_LOG) ? ltbi_pkg::FLOOR_LOG : log_temp_i;
      xd_q    <= (log_dens_i < ltbi_pkg::FLOOR_LOG) ? ltbi_pkg::FLOOR_LOG : log_dens_i;
      stage_q <= (int'(stage_i) >= ltbi_pkg::STAGES) ? 4'(ltbi_pkg::STAGES - 1) : stage_i;
    end
  end

  // Linear scan for the first grid point that is not below the input.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q  <= '0;
      tag_q <= '0;
      vld_q <= 1'b0;
    end else if (cmd_i.eval_start) begin
      sc_q  <= '0;
      vld_q <= 1'b0;
    end else if (cmd_i.scan) begin
      sc_q  <= sc_q + SW'(1);
      tag_q <= sc_q;
      vld_q <= 1'b1;
    end else begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_start) begin
      found_t_q <= 1'b0;
      found_d_q <= 1'b0;
    end else if (vld_q) begin
      if (!found_t_q && tag_q < nt && tg_rd_q >= xt_q) begin
        found_t_q <= 1'b1;
        idx_t_q   <= tag_q;
      end
      if (!found_d_q && tag_q < nd && dg_rd_q >= xd_q) begin
        found_d_q <= 1'b1;
        idx_d_q   <= tag_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve) begin
      if (!found_t_q) begin
        flag_t_q <= ltbi_pkg::CLAMP_ABOVE;
        lo_t_q   <= TW'(nt - SW'(2));
      end else if (idx_t_q == '0) begin
        flag_t_q <= ltbi_pkg::CLAMP_BELOW;
        lo_t_q   <= '0;
      end else begin
        flag_t_q <= ltbi_pkg::CLAMP_NONE;
        lo_t_q   <= TW'(idx_t_q - SW'(1));
      end
      if (!found_d_q) begin
        flag_d_q <= ltbi_pkg::CLAMP_ABOVE;
        lo_d_q   <= DW'(nd - SW'(2));
      end else if (idx_d_q == '0) begin
        flag_d_q <= ltbi_pkg::CLAMP_BELOW;
        lo_d_q   <= '0;
      end else begin
        flag_d_q <= ltbi_pkg::CLAMP_NONE;
        lo_d_q   <= DW'(idx_d_q - SW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grd_q <= ltbi_pkg::GRD_NONE;
    end else begin
      grd_q <= cmd_i.grd;
    end
  end

  always_ff @(posedge clk_i) begin
    case (grd_q)
      ltbi_pkg::GRD_LO: begin
        glo_t_q <= tg_rd_q;
        glo_d_q <= dg_rd_q;
      end
      ltbi_pkg::GRD_HI: begin
        ghi_t_q <= tg_rd_q;
        ghi_d_q <= dg_rd_q;
      end
      default: begin
      end
    endcase
  end

  // A clamped input sits on the grid end that it left.
  always_comb begin
    case (flag_t_q)
      ltbi_pkg::CLAMP_ABOVE: xe_t = ghi_t_q;
      ltbi_pkg::CLAMP_BELOW: xe_t = glo_t_q;
      default:               xe_t = xt_q;
    endcase
    case (flag_d_q)
      ltbi_pkg::CLAMP_ABOVE: xe_d = ghi_d_q;
      ltbi_pkg::CLAMP_BELOW: xe_d = glo_d_q;
      default:               xe_d = xd_q;
    endcase
    num_t = 25'(xe_t) - 25'(glo_t_q);
    den_t = 25'(ghi_t_q) - 25'(glo_t_q);
    num_d = 25'(xe_d) - 25'(glo_d_q);
    den_d = 25'(ghi_d_q) - 25'(glo_d_q);
  end

  ltbi_div u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_t),
    .den_i   (den_t),
    .busy_o  (busy_t),
    .quot_o  (wt)
  );

  ltbi_div u_div_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_d),
    .den_i   (den_d),
    .busy_o  (busy_d),
    .quot_o  (wd)
  );

  assign om_wt = 17'(ltbi_pkg::ONE_Q16 - int'(wt));
  assign om_wd = 17'(ltbi_pkg::ONE_Q16 - int'(wd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= 1'b0;
      mv_q <= 1'b0;
    end else begin
      cv_q <= cmd_i.crd_en;
      mv_q <= cmd_i.mac_en;
    end
  end

  always_ff @(posedge clk_i) begin
    csel_q <= cmd_i.corner;
    if (cv_q) begin
      c_q[csel_q] <= cf_rd_q;
    end
  end

  // The first pass weights along density; the second splits each 41-bit
  // partial sum into a low 20-bit part and a high part.
  always_comb begin
    case (cmd_i.mac_op)
      ltbi_pkg::MAC_C00: begin
        opa = 25'(c_q[0]);
        opb = $signed({1'b0, om_wd});
      end
      ltbi_pkg::MAC_C01: begin
        opa = 25'(c_q[1]);
        opb = $signed({1'b0, wd});
      end
      ltbi_pkg::MAC_C10: begin
        opa = 25'(c_q[2]);
        opb = $signed({1'b0, om_wd});
      end
      ltbi_pkg::MAC_C11: begin
        opa = 25'(c_q[3]);
        opb = $signed({1'b0, wd});
      end
      ltbi_pkg::MAC_ALO: begin
        opa = $signed({5'b0, acc_a_q[19:0]});
        opb = $signed({1'b0, om_wt});
      end
      ltbi_pkg::MAC_AHI: begin
        opa = 25'($signed(acc_a_q[40:20]));
        opb = $signed({1'b0, om_wt});
      end
      ltbi_pkg::MAC_BLO: begin
        opa = $signed({5'b0, acc_b_q[19:0]});
        opb = $signed({1'b0, wt});
      end
      ltbi_pkg::MAC_BHI: begin
        opa = 25'($signed(acc_b_q[40:20]));
        opb = $signed({1'b0, wt});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) begin
      p_q   <= opa * opb;
      mop_q <= cmd_i.mac_op;
    end
  end

  assign p_ext = 58'(p_q);

  always_ff @(posedge clk_i) begin
    if (mv_q) begin
      case (mop_q)
        ltbi_pkg::MAC_C00: acc_a_q <= 41'(p_q);
        ltbi_pkg::MAC_C01: acc_a_q <= acc_a_q + 41'(p_q);
        ltbi_pkg::MAC_C10: acc_b_q <= 41'(p_q);
        ltbi_pkg::MAC_C11: acc_b_q <= acc_b_q + 41'(p_q);
        ltbi_pkg::MAC_ALO: acc_q   <= p_ext;
        ltbi_pkg::MAC_AHI: acc_q   <= acc_q + (p_ext <<< 20);
        ltbi_pkg::MAC_BLO: acc_q   <= acc_q + p_ext;
        ltbi_pkg::MAC_BHI: acc_q   <= acc_q + (p_ext <<< 20);
        default: begin
        end
      endcase
    end
  end

  assign rsum = acc_q + 58'sd2147483648;
  assign rnd  = rsum[57:32];

  always_comb begin
    if (rnd > 26'sd8388607) begin
      sat = 24'sd8388607;
    end else if (rnd < -26'sd8388608) begin
      sat = -24'sd8388608;
    end else begin
      sat = rnd[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      log_rate_o   <= sat;
      temp_clamp_o <= flag_t_q;
      dens_clamp_o <= flag_d_q;
    end
  end

endmodule
